// ===== hw/rtl/rlss_pkg.sv =====
package rlss_pkg;

    localparam int MAX_PIXELS = 256;
    localparam int PIX_AW     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int PTR_W      = $clog2(MAX_PIXELS + 1);
    localparam int CFG_W      = 9;
    localparam int ACT_W      = (PTR_W > CFG_W) ? PTR_W : CFG_W;
    localparam int WORD_W     = 15;
    localparam int CH_W       = 5;

    localparam logic [4:0] HDR_LAST_BIT = 5'd31;
    localparam logic [4:0] PIX_LAST_BIT = 5'd15;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PIXEL,
        PH_TRAILER
    } t_phase;

    // where the data bit of a pulse comes from
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_ONE,
        SRC_LINE,
        SRC_STORE
    } t_src;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_beat;

    typedef struct packed {
        logic data_bit;
        logic frame_last;
    } t_out_beat;

endpackage

// ===== hw/rtl/rgb555_led_strip_serializer_unit.sv =====
// Channel  | Dir | Handshake                 | Payload
// ---------+-----+---------------------------+---------------------------
// in       | in  | i_in_valid / o_in_ready   | i_in_beat  (t_in_beat)
// out      | out | o_out_valid / i_out_ready | o_out_beat (t_out_beat)
// cfg      | in  | i_cfg_we                  | i_cfg_wdata (pixel count)
//
// One input beat per cycle. A tick that emits a pulse shows its result in the
// cycle after acceptance; the delay is set by the registered store read.
// Reset clears control state and the per-entry valid bits; an unwritten
// pixel reads as zero, so no clearing pass is needed.
// A stalled output holds the result register and blocks further input.
module rgb555_led_strip_serializer_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  rlss_pkg::t_in_beat        i_in_beat,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output rlss_pkg::t_out_beat       o_out_beat,
    input  logic                      i_cfg_we,
    input  logic [rlss_pkg::CFG_W-1:0] i_cfg_wdata
);
    import rlss_pkg::*;

    logic [CFG_W-1:0]  r_pixel_count;
    logic              r_sending, n_sending;
    t_phase            r_phase, n_phase;
    logic [4:0]        r_bc, n_bc;
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic              r_line_level;

    logic [WORD_W-1:0] r_store [MAX_PIXELS];
    logic [MAX_PIXELS-1:0] r_vld;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_rd_vld;

    logic              r_out_valid;
    t_src              r_src, n_src;
    logic [3:0]        r_bit_idx, n_bit_idx;
    logic              r_last, n_last;

    logic              accept;
    logic              wr_en;
    logic              rd_en;
    logic [PIX_AW-1:0] wr_addr;
    logic [PIX_AW-1:0] rd_addr;
    logic [WORD_W-1:0] wr_word;
    logic [ACT_W-1:0]  act_count;
    logic [PTR_W-1:0]  ptr_inc;
    logic              out_bit;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    assign act_count = (ACT_W'(r_pixel_count) > ACT_W'(MAX_PIXELS))
                     ? ACT_W'(MAX_PIXELS) : ACT_W'(r_pixel_count);
    assign ptr_inc   = r_ptr + 1'b1;

    assign wr_en   = accept && (i_in_beat.kind == KIND_WRITE)
                  && (ACT_W'(i_in_beat.pixel_index) < ACT_W'(MAX_PIXELS));
    assign wr_addr = PIX_AW'(i_in_beat.pixel_index);
    assign wr_word = {i_in_beat.green[CH_W-1:0], i_in_beat.blue[CH_W-1:0],
                      i_in_beat.red[CH_W-1:0]};
    assign rd_en   = accept && (i_in_beat.kind == KIND_TICK) && r_sending;
    assign rd_addr = (r_ptr < PTR_W'(MAX_PIXELS)) ? r_ptr[PIX_AW-1:0] : '0;

    always_comb begin
        n_sending = r_sending;
        n_phase   = r_phase;
        n_bc      = r_bc;
        n_ptr     = r_ptr;
        n_src     = SRC_ZERO;
        n_bit_idx = '0;
        n_last    = 1'b0;
        if (accept && (i_in_beat.kind == KIND_START) && !r_sending) begin
            n_sending = 1'b1;
            n_phase   = PH_HEADER;
            n_bc      = '0;
            n_ptr     = '0;
        end else if (rd_en) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_src = SRC_ZERO;
                    if (r_bc >= HDR_LAST_BIT) begin
                        n_bc    = '0;
                        n_ptr   = '0;
                        n_phase = (act_count != '0) ? PH_PIXEL : PH_TRAILER;
                    end else begin
                        n_bc = r_bc + 1'b1;
                    end
                end
                PH_PIXEL: begin
                    n_src     = (r_bc == '0) ? SRC_ONE : SRC_STORE;
                    n_bit_idx = 4'(PIX_LAST_BIT - r_bc);
                    if (r_bc >= PIX_LAST_BIT) begin
                        n_bc  = '0;
                        n_ptr = ptr_inc;
                        if (ACT_W'(ptr_inc) >= act_count) begin
                            n_phase = PH_TRAILER;
                        end
                    end else begin
                        n_bc = r_bc + 1'b1;
                    end
                end
                default: begin
                    if (r_bc == '0) begin
                        n_src = SRC_LINE;
                        n_bc  = 5'd1;
                    end else begin
                        n_src     = SRC_ZERO;
                        n_last    = 1'b1;
                        n_sending = 1'b0;
                        n_phase   = PH_HEADER;
                        n_bc      = '0;
                        n_ptr     = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= '0;
            r_sending     <= 1'b0;
            r_phase       <= PH_HEADER;
            r_bc          <= '0;
            r_ptr         <= '0;
            r_line_level  <= 1'b0;
            r_out_valid   <= 1'b0;
            r_vld         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_pixel_count <= i_cfg_wdata;
            end
            r_sending   <= n_sending;
            r_phase     <= n_phase;
            r_bc        <= n_bc;
            r_ptr       <= n_ptr;
            r_out_valid <= rd_en || (r_out_valid && !i_out_ready);
            if (r_out_valid && i_out_ready) begin
                r_line_level <= out_bit;
            end
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
    end

    // store: one write and one read port, read data registered
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_word;
        end
        if (rd_en) begin
            r_rd_data <= r_store[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
            r_src     <= n_src;
            r_bit_idx <= n_bit_idx;
            r_last    <= n_last;
        end
    end

    always_comb begin
        unique case (r_src)
            SRC_ZERO:  out_bit = 1'b0;
            SRC_ONE:   out_bit = 1'b1;
            SRC_LINE:  out_bit = r_line_level;
            SRC_STORE: out_bit = r_rd_vld && r_rd_data[r_bit_idx];
            default:   out_bit = 1'b0;
        endcase
    end

    assign o_out_beat.data_bit   = out_bit;
    assign o_out_beat.frame_last = r_last;

endmodule

// ===== hw/rtl/rlss_checker.sv =====
module rlss_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input rlss_pkg::t_in_beat         i_in_beat,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input rlss_pkg::t_out_beat        o_out_beat,
    input logic                       i_cfg_we,
    input logic [rlss_pkg::CFG_W-1:0] i_cfg_wdata
);
    import rlss_pkg::*;

    // final pulse of a frame is always low
    a_last_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.frame_last |-> !o_out_beat.data_bit)
        else $error("frame_last beat with data_bit high");

    // a new result only follows an accepted tick
    a_rose_after_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(i_in_valid && o_in_ready && (i_in_beat.kind == KIND_TICK)))
        else $error("result appeared without a tick");

    // empty output stage never blocks input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("stalled output beat changed");

endmodule

bind rgb555_led_strip_serializer_unit rlss_checker u_rlss_checker (.*);

// ===== tb/rgb555_led_strip_serializer_unit_tb.sv =====
module rgb555_led_strip_serializer_unit_tb;
    import rlss_pkg::*;

    localparam logic [1:0] KIND_NONE   = 2'd3;
    localparam int         LIMIT       = 200000;
    localparam int         HOLD_CYCLES = 300;
    localparam int         SETTLE      = 4;

    typedef enum logic [1:0] {
        WANT_PREDICTED,
        WANT_NOTHING,
        WANT_PULSE
    } t_want;

    typedef struct {
        t_in_beat  beat;
        t_want     want;
        t_out_beat pulse;
    } t_dir_row;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_in_beat         i_in_beat   = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_beat        o_out_beat;
    logic             i_cfg_we    = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    rgb555_led_strip_serializer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // strip state as the block should hold it
    logic [WORD_W-1:0] px_store [MAX_PIXELS];
    logic              busy;
    t_phase            frame_ph;
    logic [4:0]        bit_cnt;
    logic [PTR_W-1:0]  px_ptr;
    logic              line_lvl;
    logic [CFG_W-1:0]  strip_len;
    t_out_beat         pulse_q[$];

    int        errs        = 0;
    int        cycles      = 0;
    int        beats_in    = 0;
    int        pulses_seen = 0;
    int        frames_seen = 0;
    int        snd_idle    = 0;
    int        stall_pct   = 0;
    logic      rx_hold     = 1'b0;
    t_out_beat head_pulse;
    t_dir_row  dir_rows[$];

    function automatic int active_len();
        return (strip_len > MAX_PIXELS) ? MAX_PIXELS : int'(strip_len);
    endfunction

    function automatic logic next_pulse(input t_in_beat b, output t_out_beat p);
        logic              got;
        logic              lvl;
        logic [PIX_AW-1:0] sel;
        got = 1'b0;
        lvl = 1'b0;
        p   = '0;
        case (b.kind)
            KIND_WRITE: begin
                px_store[b.pixel_index] = {b.green[CH_W-1:0], b.blue[CH_W-1:0],
                                           b.red[CH_W-1:0]};
            end
            KIND_START: begin
                if (!busy) begin
                    busy     = 1'b1;
                    frame_ph = PH_HEADER;
                    bit_cnt  = '0;
                    px_ptr   = '0;
                end
            end
            KIND_TICK: begin
                if (busy) begin
                    got = 1'b1;
                    case (frame_ph)
                        PH_HEADER: begin
                            if (bit_cnt >= HDR_LAST_BIT) begin
                                bit_cnt  = '0;
                                px_ptr   = '0;
                                frame_ph = (active_len() > 0) ? PH_PIXEL : PH_TRAILER;
                            end else begin
                                bit_cnt = bit_cnt + 5'd1;
                            end
                        end
                        PH_PIXEL: begin
                            if (bit_cnt == 0) begin
                                lvl = 1'b1;
                            end else begin
                                sel = (px_ptr < MAX_PIXELS) ? px_ptr[PIX_AW-1:0] : '0;
                                lvl = px_store[sel][15 - int'(bit_cnt)];
                            end
                            if (bit_cnt >= PIX_LAST_BIT) begin
                                bit_cnt = '0;
                                px_ptr  = px_ptr + 1'b1;
                                if (int'(px_ptr) >= active_len())
                                    frame_ph = PH_TRAILER;
                            end else begin
                                bit_cnt = bit_cnt + 5'd1;
                            end
                        end
                        default: begin
                            if (bit_cnt == 0) begin
                                lvl     = line_lvl;
                                bit_cnt = 5'd1;
                            end else begin
                                p.frame_last = 1'b1;
                                busy     = 1'b0;
                                frame_ph = PH_HEADER;
                                bit_cnt  = '0;
                                px_ptr   = '0;
                            end
                        end
                    endcase
                    line_lvl   = lvl;
                    p.data_bit = lvl;
                end
            end
            default: ;
        endcase
        return got;
    endfunction

    function automatic t_in_beat any_beat(input logic [1:0] k);
        t_in_beat b;
        b.kind        = k;
        b.pixel_index = 8'($urandom_range(255));
        b.red         = 8'($urandom_range(255));
        b.green       = 8'($urandom_range(255));
        b.blue        = 8'($urandom_range(255));
        return b;
    endfunction

    function automatic t_in_beat pixel_write();
        t_in_beat b;
        b = any_beat(KIND_WRITE);
        // mostly hit pixels that the current frame length will send
        if ($urandom_range(3) != 0 && active_len() > 0)
            b.pixel_index = 8'($urandom_range(active_len() - 1));
        return b;
    endfunction

    function automatic t_dir_row mk_row(input logic [1:0] k, input logic [7:0] idx,
                                        input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] bl, input t_want w,
                                        input logic db, input logic fl);
        t_dir_row row;
        row.beat.kind        = k;
        row.beat.pixel_index = idx;
        row.beat.red         = r;
        row.beat.green       = g;
        row.beat.blue        = bl;
        row.want             = w;
        row.pulse.data_bit   = db;
        row.pulse.frame_last = fl;
        return row;
    endfunction

    task automatic send_beat(input t_in_beat b, input t_want w, input t_out_beat typed);
        int        gap;
        logic      got;
        t_out_beat p;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < snd_idle)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        got = next_pulse(b, p);
        beats_in++;
        if (w == WANT_PULSE)
            pulse_q.push_back(typed);
        else if (w == WANT_PREDICTED && got)
            pulse_q.push_back(p);
    endtask

    task automatic send_rand(input t_in_beat b);
        send_beat(b, WANT_PREDICTED, '0);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pulse_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        strip_len = v;
        i_cfg_we <= 1'b0;
    endtask

    task automatic hold_rx();
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    endtask

    // well-formed frames with random content, plus some noise
    task automatic run_stage(input logic [CFG_W-1:0] len, input int idle, input int stall,
                             input int budget, input logic squeeze);
        int         n;
        int         pick;
        logic [1:0] k;
        write_count(len);
        snd_idle  = idle;
        stall_pct = stall;
        if (squeeze) begin
            fork
                hold_rx();
            join_none
        end
        n = 0;
        while (n < budget) begin
            if ($urandom_range(9) == 0) begin
                send_rand(any_beat($urandom_range(1) ? KIND_NONE : KIND_TICK));
                n++;
            end else begin
                repeat ($urandom_range(3)) begin
                    send_rand(pixel_write());
                    n++;
                end
                send_rand(any_beat(KIND_START));
                n++;
                while (busy && n < budget) begin
                    pick = $urandom_range(99);
                    if (pick < 90)
                        k = KIND_TICK;
                    else if (pick < 94)
                        k = KIND_WRITE;
                    else if (pick < 97)
                        k = KIND_START;
                    else
                        k = KIND_NONE;
                    send_rand((k == KIND_WRITE) ? pixel_write() : any_beat(k));
                    n++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (rx_hold)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pulse_q.size() == 0) begin
                $error("unexpected beat: data_bit=%0b frame_last=%0b",
                       o_out_beat.data_bit, o_out_beat.frame_last);
                errs++;
            end else begin
                head_pulse = pulse_q.pop_front();
                pulses_seen++;
                if (head_pulse.frame_last)
                    frames_seen++;
                if (o_out_beat.data_bit !== head_pulse.data_bit) begin
                    $error("data_bit: expected %0b, got %0b",
                           head_pulse.data_bit, o_out_beat.data_bit);
                    errs++;
                end
                if (o_out_beat.frame_last !== head_pulse.frame_last) begin
                    $error("frame_last: expected %0b, got %0b",
                           head_pulse.frame_last, o_out_beat.frame_last);
                    errs++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        busy      = 1'b0;
        frame_ph  = PH_HEADER;
        bit_cnt   = '0;
        px_ptr    = '0;
        line_lvl  = 1'b0;
        strip_len = '0;
        foreach (px_store[i])
            px_store[i] = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_count(9'd2);

        // tick while idle and the unused kind do nothing; header pulses are all zero
        dir_rows.push_back(mk_row(KIND_TICK,  8'd0,   8'h00, 8'h00, 8'h00,
                                  WANT_NOTHING, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(KIND_NONE,  8'hFF,  8'hFF, 8'hFF, 8'hFF,
                                  WANT_NOTHING, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(KIND_WRITE, 8'd0,   8'hFF, 8'hFF, 8'hFF,
                                  WANT_NOTHING, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(KIND_WRITE, 8'd255, 8'hE0, 8'hE0, 8'hE0,
                                  WANT_NOTHING, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(KIND_WRITE, 8'd1,   8'h15, 8'h0A, 8'h1F,
                                  WANT_NOTHING, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(KIND_START, 8'd0,   8'h00, 8'h00, 8'h00,
                                  WANT_NOTHING, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(KIND_TICK,  8'hFF,  8'hFF, 8'hFF, 8'hFF,
                                  WANT_PULSE, 1'b0, 1'b0));
        // start while a frame is running is dropped
        dir_rows.push_back(mk_row(KIND_START, 8'hFF,  8'hFF, 8'hFF, 8'hFF,
                                  WANT_NOTHING, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(KIND_TICK,  8'd0,   8'h00, 8'h00, 8'h00,
                                  WANT_PULSE, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(KIND_WRITE, 8'd255, 8'h1F, 8'h1F, 8'h1F,
                                  WANT_NOTHING, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(KIND_NONE,  8'd0,   8'h00, 8'h00, 8'h00,
                                  WANT_NOTHING, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(KIND_WRITE, 8'd1,   8'hAA, 8'h55, 8'hC3,
                                  WANT_PREDICTED, 1'b0, 1'b0));
        repeat (5)
            dir_rows.push_back(mk_row(KIND_TICK, 8'h5A, 8'hA5, 8'h3C, 8'hC3,
                                      WANT_PULSE, 1'b0, 1'b0));
        foreach (dir_rows[i])
            send_beat(dir_rows[i].beat, dir_rows[i].want, dir_rows[i].pulse);

        // the directed frame is still in its header; its length changes below
        run_stage(9'd3,   0,  0,  150, 1'b0);
        run_stage(9'd0,   63, 0,  120, 1'b0);
        run_stage(9'd1,   0,  63, 150, 1'b0);
        run_stage(9'd2,   23, 23, 150, 1'b0);
        run_stage(CFG_W'($urandom_range(4, 7)), 23, 23, 200, 1'b1);
        run_stage(9'd256, 0,  23, 130, 1'b0);
        // longer than the strip; saturates to the full strip
        run_stage(9'h1FF, 0,  0,  130, 1'b0);

        drain();
        $display("Sent %0d beats; checked %0d pulses across %0d finished frames,",
                 beats_in, pulses_seen, frames_seen);
        $display("strip length 0 to 511 (saturated), with idle, stall and hold-off spells.");
        if (errs == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
